// ===== design/lru_pr_pkg.sv =====
package lru_pr_pkg;

    localparam int CFG_W           = 5;
    localparam int PAGE_W          = 16;
    localparam int FRAME_OUT_W     = 4;
    localparam int TOTAL_W         = 32;
    localparam int FRAMES_DEF      = 16;
    localparam int PAGE_BITS_DEF   = 16;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    typedef logic [TOTAL_W-1:0] t_total;

endpackage

// ===== design/lru_page_replacement_unit.sv =====
// LRU page replacement unit. Each transfer on the page channel is one page reference;
// the block answers with one result transfer that tells whether the page was resident,
// which frame now holds it, which page was evicted (if any) and the saturating hit and
// fault totals. An accepted item scans the frames one per cycle through the page
// memory's single read port, picks the frame, ages the recency ranks one frame per
// cycle and hands the result to the output register, which is held off for as long
// as an earlier result still waits there. The page channel is ready only between
// items, so a reference is taken only once the last one is through; a result may
// wait in the output register while the next item is taken. The user must write
// frames_in_use through i_cfg_we / i_cfg_data only while idle; the block itself does
// not enforce this. 0 acts as 1 and values above FRAMES act as FRAMES.
module lru_page_replacement_unit #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [lru_pr_pkg::CFG_W-1:0]      i_cfg_data,

    input  logic                              i_page_valid,
    output logic                              o_page_ready,
    input  logic [lru_pr_pkg::PAGE_W-1:0]     i_page_number,

    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic                              o_hit,
    output logic [lru_pr_pkg::FRAME_OUT_W-1:0] o_frame_index,
    output logic                              o_evicted_valid,
    output logic [lru_pr_pkg::PAGE_W-1:0]     o_evicted_page,
    output logic [lru_pr_pkg::TOTAL_W-1:0]    o_hit_total,
    output logic [lru_pr_pkg::TOTAL_W-1:0]    o_fault_total
);
    import lru_pr_pkg::*;

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1) + 1;
    localparam int RANK_W = IDX_W;
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_AGE    = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;

    localparam t_total TOTAL_MAX = '1;

    logic [2:0]              r_state;
    logic [CFG_W-1:0]        r_frames_in_use;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_filled;
    logic [PAGE_BITS-1:0]    r_req_page;

    logic [FRAMES-1:0]       r_valid;
    logic [RANK_W-1:0]       r_rank [FRAMES];
    logic [PAGE_BITS-1:0]    r_page_mem [FRAMES];

    // scan pipeline: memory read data lines up with these
    logic                    r_pipe_v;
    logic [IDX_W-1:0]        r_pipe_idx;
    logic                    r_pipe_valid;
    logic [RANK_W-1:0]       r_pipe_rank;
    logic [PAGE_BITS-1:0]    r_rd_page;

    logic                    r_found;
    logic [IDX_W-1:0]        r_found_idx;
    logic [RANK_W-1:0]       r_found_rank;
    logic                    r_any;
    logic [IDX_W-1:0]        r_best_idx;
    logic [RANK_W-1:0]       r_best_rank;
    logic [PAGE_BITS-1:0]    r_best_page;

    logic [IDX_W-1:0]        r_f;
    logic [RANK_W-1:0]       r_old_rank;
    logic                    r_age_all;
    logic                    r_hit;
    logic                    r_ev_valid;
    logic [PAGE_W-1:0]       r_ev_page;
    t_total                  r_hits;
    t_total                  r_faults;

    logic                    r_o_valid;
    logic                    r_o_hit;
    logic [FRAME_OUT_W-1:0]  r_o_frame;
    logic                    r_o_ev_valid;
    logic [PAGE_W-1:0]       r_o_ev_page;
    t_total                  r_o_hits;
    t_total                  r_o_faults;

    logic [2:0]              n_state;
    logic [IDX_W-1:0]        w_scan_addr;
    logic                    w_scan_issue;
    logic [LIM_W-1:0]        w_limit;
    logic                    w_can_fill;
    logic                    w_out_free;
    logic [IDX_W-1:0]        w_age_k;
    logic                    w_age_last;
    logic [IDX_W-1:0]        w_dec_f;
    logic                    w_dec_write;

    assign o_page_ready = (r_state == S_IDLE);
    assign w_out_free   = !r_o_valid || i_res_ready;
    assign w_scan_issue = (r_state == S_SCAN) && (r_idx < CNT_W'(FRAMES));
    assign w_scan_addr  = r_idx[IDX_W-1:0];
    assign w_age_k      = r_idx[IDX_W-1:0];
    assign w_age_last   = (r_idx == CNT_W'(FRAMES - 1));

    // effective limit: 0 acts as 1, clamp to FRAMES
    always_comb begin
        w_limit = LIM_W'(r_frames_in_use);
        if (r_frames_in_use == '0) begin
            w_limit = LIM_W'(1);
        end else if (LIM_W'(r_frames_in_use) > LIM_W'(FRAMES)) begin
            w_limit = LIM_W'(FRAMES);
        end
    end

    assign w_can_fill = (LIM_W'(r_filled) < w_limit) && (r_filled < CNT_W'(FRAMES));

    always_comb begin
        if (w_can_fill) begin
            w_dec_f = r_filled[IDX_W-1:0];
        end else begin
            w_dec_f = r_best_idx;
        end
    end
    assign w_dec_write = (r_state == S_DECIDE) && !r_found;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_page_valid) n_state = S_SCAN;
            S_SCAN:   if (!w_scan_issue) n_state = S_DECIDE;
            S_DECIDE: n_state = S_AGE;
            S_AGE:    if (w_age_last) n_state = S_WAIT;
            S_WAIT:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // page memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_dec_write) begin
            r_page_mem[w_dec_f] <= r_req_page;
        end
        r_rd_page <= r_page_mem[w_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frames_in_use <= FRAMES_IN_USE_RST;
            r_idx           <= '0;
            r_filled        <= '0;
            r_valid         <= '0;
            r_pipe_v        <= 1'b0;
            r_hits          <= '0;
            r_faults        <= '0;
            r_o_valid       <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_data;
            end
            // in S_WAIT the output register is reloaded below instead
            if (r_o_valid && i_res_ready && (r_state != S_WAIT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_page_valid) begin
                        r_req_page <= PAGE_BITS'(i_page_number);
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_any      <= 1'b0;
                        r_best_idx <= '0;
                        r_best_rank <= '0;
                        r_best_page <= '0;
                    end
                end
                S_SCAN: begin
                    r_pipe_v <= w_scan_issue;
                    if (w_scan_issue) begin
                        r_pipe_idx   <= w_scan_addr;
                        r_pipe_valid <= r_valid[w_scan_addr];
                        r_pipe_rank  <= r_rank[w_scan_addr];
                        r_idx        <= r_idx + CNT_W'(1);
                    end
                    if (r_pipe_v && r_pipe_valid) begin
                        // first match wins
                        if (!r_found && (r_rd_page == r_req_page)) begin
                            r_found      <= 1'b1;
                            r_found_idx  <= r_pipe_idx;
                            r_found_rank <= r_pipe_rank;
                        end
                        // oldest frame, ties to the lowest index
                        if (!r_any || (r_pipe_rank > r_best_rank)) begin
                            r_any       <= 1'b1;
                            r_best_idx  <= r_pipe_idx;
                            r_best_rank <= r_pipe_rank;
                            r_best_page <= r_rd_page;
                        end
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    r_hit <= r_found;
                    if (r_found) begin
                        if (r_hits != TOTAL_MAX) begin
                            r_hits <= r_hits + t_total'(1);
                        end
                        r_f        <= r_found_idx;
                        r_old_rank <= r_found_rank;
                        r_age_all  <= 1'b0;
                        r_ev_valid <= 1'b0;
                        r_ev_page  <= '0;
                    end else begin
                        if (r_faults != TOTAL_MAX) begin
                            r_faults <= r_faults + t_total'(1);
                        end
                        r_f              <= w_dec_f;
                        r_valid[w_dec_f] <= 1'b1;
                        if (w_can_fill) begin
                            r_filled   <= r_filled + CNT_W'(1);
                            r_age_all  <= 1'b1;
                            r_old_rank <= '0;
                            r_ev_valid <= 1'b0;
                            r_ev_page  <= '0;
                        end else begin
                            r_age_all  <= !r_any;
                            r_old_rank <= r_best_rank;
                            r_ev_valid <= r_any;
                            r_ev_page  <= r_any ? PAGE_W'(r_best_page) : '0;
                        end
                    end
                end
                S_AGE: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (w_age_k == r_f) begin
                        r_rank[w_age_k] <= '0;
                    end else if (r_valid[w_age_k] &&
                                 (r_age_all || (r_rank[w_age_k] < r_old_rank))) begin
                        r_rank[w_age_k] <= r_rank[w_age_k] + RANK_W'(1);
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_hit      <= r_hit;
                        r_o_frame    <= FRAME_OUT_W'(r_f);
                        r_o_ev_valid <= r_ev_valid;
                        r_o_ev_page  <= r_ev_page;
                        r_o_hits     <= r_hits;
                        r_o_faults   <= r_faults;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res_valid     = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_frame;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_hit_total     = r_o_hits;
    assign o_fault_total   = r_o_faults;

endmodule
